// ===== src/ptp_slew_pkg.sv =====
// Shared constants and types for the pedal-to-PWM slew limiter.
package ptp_slew_pkg;

    localparam int unsigned FULL_SCALE_DEF = 1023;

    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned DBAND_W   = 9;
    localparam int unsigned SCALED_W  = 21;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DUTY   = 3'd0,
        CFG_MAX_DUTY   = 3'd1,
        CFG_PEDAL_LOW  = 3'd2,
        CFG_PEDAL_HIGH = 3'd3,
        CFG_LOW_DBAND  = 3'd4,
        CFG_HIGH_DBAND = 3'd5,
        CFG_ACCEL_STEP = 3'd6,
        CFG_DECEL_STEP = 3'd7
    } cfg_idx_t;

    localparam logic [DUTY_W-1:0]   RST_MIN_DUTY   = 10'd0;
    localparam logic [DUTY_W-1:0]   RST_MAX_DUTY   = 10'd511;
    localparam logic [SAMPLE_W-1:0] RST_PEDAL_LOW  = 10'd0;
    localparam logic [SAMPLE_W-1:0] RST_PEDAL_HIGH = 10'd1023;
    localparam logic [DBAND_W-1:0]  RST_LOW_DBAND  = 9'd50;
    localparam logic [DBAND_W-1:0]  RST_HIGH_DBAND = 9'd50;
    localparam logic [DUTY_W-1:0]   RST_ACCEL_STEP = 10'd10;
    localparam logic [DUTY_W-1:0]   RST_DECEL_STEP = 10'd10;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/ptp_slew_div.sv =====
// Bit-serial signed divider, quotient truncated toward zero.
module ptp_slew_div
    import ptp_slew_pkg::*;
#(
    parameter int unsigned NUM_W = 33,
    parameter int unsigned DEN_W = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] numer,
    input  logic signed [DEN_W-1:0] denom,
    output logic signed [NUM_W-1:0] quotient,
    output div_status_t             status
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;

        if (start) begin
            // latch magnitudes and the quotient sign
            quo_next  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
            den_next  = denom[DEN_W-1] ? DEN_W'(-denom) : DEN_W'(denom);
            neg_next  = numer[NUM_W-1] ^ denom[DEN_W-1];
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign quotient    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== src/pedal_to_pwm_slew_limiter.sv =====
// Top level: pedal-to-PWM throttle map with deadband and slew-rate limiter.
//
// One word in per control tick on the s_ channel, one result word out on the
// m_ channel. The pedal sample is mapped from the pedal read range onto
// 0..FULL_SCALE, the selected source (mapped pedal or override level) is then
// mapped from the deadband window onto min_duty..max_duty and clamped, and the
// kept duty level moves toward that demand by at most accel_step or
// decel_step, then is clamped again.
//
// A word passes the states MAP1, DIV1, SRC, DIV2, DEMAND and SLEW from accept to
// result; an empty read range skips DIV1 and an empty deadband window skips DIV2.
// s_tready rises as the result is loaded, so a new word is taken only once the
// last one is through. Both divisions run on one bit-serial divider, one
// quotient bit per cycle.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds its finished word until that register frees up and s_tready
// stays low. Write configuration through cfg_wr_en/cfg_addr/cfg_wdata only
// while no word is in flight. Reset (aresetn low, synchronous) restores the
// default registers, clears the duty level and drops any word in flight.
module pedal_to_pwm_slew_limiter
    import ptp_slew_pkg::*;
#(
    parameter int unsigned FULL_SCALE = FULL_SCALE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input word
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // pedal_sample[9:0], override_level[19:10]
    input  logic                 s_tuser,   // override_on
    // result word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // duty_out[9:0], throttle_demand[19:10],
                                            // pedal_scaled[40:20]
    output logic                 m_tuser,   // range_fault
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int unsigned FS_W  = $clog2(FULL_SCALE + 1);
    localparam int unsigned SW    = FS_W + 11;                  // mapped pedal, signed
    localparam int unsigned AW    = FS_W + 12;                  // multiplier A, signed
    localparam int unsigned BW    = (FS_W + 1 > 11) ? FS_W + 1 : 11;
    localparam int unsigned NUM_W = AW + BW;                    // product / dividend
    localparam int unsigned DEN_W = (FS_W + 2 > 11) ? FS_W + 2 : 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP1,
        ST_DIV1,
        ST_SRC,
        ST_DIV2,
        ST_DEMAND,
        ST_SLEW
    } state_t;

    // configuration registers
    logic [DUTY_W-1:0]   min_duty_reg, max_duty_reg;
    logic [SAMPLE_W-1:0] pedal_low_reg, pedal_high_reg;
    logic [DBAND_W-1:0]  low_dband_reg, high_dband_reg;
    logic [DUTY_W-1:0]   accel_step_reg, decel_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duty_reg   <= RST_MIN_DUTY;
            max_duty_reg   <= RST_MAX_DUTY;
            pedal_low_reg  <= RST_PEDAL_LOW;
            pedal_high_reg <= RST_PEDAL_HIGH;
            low_dband_reg  <= RST_LOW_DBAND;
            high_dband_reg <= RST_HIGH_DBAND;
            accel_step_reg <= RST_ACCEL_STEP;
            decel_step_reg <= RST_DECEL_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MIN_DUTY:   min_duty_reg   <= cfg_wdata;
                CFG_MAX_DUTY:   max_duty_reg   <= cfg_wdata;
                CFG_PEDAL_LOW:  pedal_low_reg  <= cfg_wdata;
                CFG_PEDAL_HIGH: pedal_high_reg <= cfg_wdata;
                CFG_LOW_DBAND:  low_dband_reg  <= cfg_wdata[DBAND_W-1:0];
                CFG_HIGH_DBAND: high_dband_reg <= cfg_wdata[DBAND_W-1:0];
                CFG_ACCEL_STEP: accel_step_reg <= cfg_wdata;
                CFG_DECEL_STEP: decel_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state and datapath registers
    state_t                   state_reg, state_next;
    logic [SAMPLE_W-1:0]      raw_reg, raw_next;
    logic                     ovr_reg, ovr_next;
    logic [SAMPLE_W-1:0]      ovr_lvl_reg, ovr_lvl_next;
    logic                     fault_reg, fault_next;
    logic signed [SW-1:0]     scaled_reg, scaled_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [DEN_W-1:0]  den_reg, den_next;
    logic signed [NUM_W-1:0]  quot_reg, quot_next;
    logic                     start_reg, start_next;
    logic [DUTY_W-1:0]        demand_reg, demand_next;
    logic [DUTY_W-1:0]        duty_level_reg, duty_level_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [47:0]              m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    logic signed [NUM_W-1:0]  div_quot;
    div_status_t              div_status;

    ptp_slew_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .numer    (num_reg),
        .denom    (den_reg),
        .quotient (div_quot),
        .status   (div_status)
    );

    // shared multiplier operands, selected by the sequencer
    logic signed [10:0]       diff1;
    logic signed [SW-1:0]     src;
    logic signed [AW-1:0]     diff2;
    logic signed [10:0]       duty_span;
    logic signed [DEN_W-1:0]  span1, span2;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [NUM_W-1:0]  product;

    // demand and slew arithmetic
    logic signed [NUM_W:0]    dem_raw;
    logic signed [NUM_W:0]    lo_w, hi_w;
    logic signed [11:0]       duty_s, demand_s, up_s, down_s, step_s, lo_s, hi_s;
    logic signed [11:0]       slewed;
    logic                     out_free, out_load, in_accept;

    always_comb begin
        diff1     = $signed({1'b0, raw_reg}) - $signed({1'b0, pedal_low_reg});
        span1     = DEN_W'($signed({1'b0, pedal_high_reg}) - $signed({1'b0, pedal_low_reg}));
        src       = ovr_reg ? $signed(SW'({1'b0, ovr_lvl_reg})) : scaled_reg;
        diff2     = AW'(src) - $signed(AW'({1'b0, low_dband_reg}));
        duty_span = $signed({1'b0, max_duty_reg}) - $signed({1'b0, min_duty_reg});
        span2     = $signed(DEN_W'(FULL_SCALE)) - $signed(DEN_W'({1'b0, high_dband_reg}))
                    - $signed(DEN_W'({1'b0, low_dband_reg}));

        if (state_reg == ST_MAP1) begin
            mul_a = AW'(diff1);
            mul_b = $signed(BW'(FULL_SCALE));
        end else begin
            mul_a = diff2;
            mul_b = BW'(duty_span);
        end
        product = NUM_W'(mul_a) * NUM_W'(mul_b);

        // demand: quotient plus lower bound, clamp with lower bound first
        lo_w    = $signed((NUM_W + 1)'({1'b0, min_duty_reg}));
        hi_w    = $signed((NUM_W + 1)'({1'b0, max_duty_reg}));
        dem_raw = (NUM_W + 1)'(quot_reg) + lo_w;

        // slew toward demand, then clamp again
        duty_s   = $signed({2'b00, duty_level_reg});
        demand_s = $signed({2'b00, demand_reg});
        lo_s     = $signed({2'b00, min_duty_reg});
        hi_s     = $signed({2'b00, max_duty_reg});
        step_s   = $signed({2'b00, accel_step_reg});
        up_s     = duty_s + step_s;
        down_s   = duty_s - $signed({2'b00, decel_step_reg});
        if (demand_s > duty_s) begin
            slewed = (demand_s < up_s) ? demand_s : up_s;
        end else if (demand_s < duty_s) begin
            slewed = (demand_s > down_s) ? demand_s : down_s;
        end else begin
            slewed = duty_s;
        end
        if (slewed < lo_s) begin
            slewed = lo_s;
        end else if (slewed > hi_s) begin
            slewed = hi_s;
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == ST_SLEW) && out_free;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        raw_next        = raw_reg;
        ovr_next        = ovr_reg;
        ovr_lvl_next    = ovr_lvl_reg;
        fault_next      = fault_reg;
        scaled_next     = scaled_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        quot_next       = quot_reg;
        start_next      = 1'b0;
        demand_next     = demand_reg;
        duty_level_next = duty_level_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    raw_next     = s_tdata[9:0];
                    ovr_lvl_next = s_tdata[19:10];
                    ovr_next     = s_tuser;
                    state_next   = ST_MAP1;
                end
            end
            ST_MAP1: begin
                // empty read range: mapped pedal is zero, skip the division
                fault_next = (pedal_high_reg == pedal_low_reg);
                num_next   = product;
                den_next   = span1;
                if (pedal_high_reg == pedal_low_reg) begin
                    scaled_next = '0;
                    state_next  = ST_SRC;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_status.done) begin
                    scaled_next = SW'(div_quot);
                    state_next  = ST_SRC;
                end
            end
            ST_SRC: begin
                num_next = product;
                den_next = span2;
                // empty deadband window: demand is the lower bound
                if (span2 == '0) begin
                    quot_next  = '0;
                    state_next = ST_DEMAND;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_status.done) begin
                    quot_next  = div_quot;
                    state_next = ST_DEMAND;
                end
            end
            ST_DEMAND: begin
                if (dem_raw < lo_w) begin
                    demand_next = min_duty_reg;
                end else if (dem_raw > hi_w) begin
                    demand_next = max_duty_reg;
                end else begin
                    demand_next = dem_raw[DUTY_W-1:0];
                end
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                // hold the finished word until the output register frees up
                if (out_free) begin
                    duty_level_next = slewed[DUTY_W-1:0];
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = {7'd0, SCALED_W'(scaled_reg), demand_reg,
                                       slewed[DUTY_W-1:0]};
                    m_tuser_next    = fault_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            start_reg      <= 1'b0;
            duty_level_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            duty_level_reg <= duty_level_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        raw_reg     <= raw_next;
        ovr_reg     <= ovr_next;
        ovr_lvl_reg <= ovr_lvl_next;
        fault_reg   <= fault_next;
        scaled_reg  <= scaled_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        quot_reg    <= quot_next;
        demand_reg  <= demand_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a fault word always reports a zero mapped pedal
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[40:20] == 21'd0))
        else $error("range fault with nonzero pedal_scaled");

    // the kept duty level is the duty just sent
    a_duty_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (duty_level_reg == m_tdata_reg[9:0]))
        else $error("duty level differs from delivered duty");

    // a loaded duty stays inside an ordered duty range
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (min_duty_reg <= max_duty_reg)) |->
        (slewed >= lo_s && slewed <= hi_s))
        else $error("duty outside min/max range");

    // the divider is only started while it is free
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !div_status.busy)
        else $error("divider started while busy");

endmodule

// ===== verif/tb_pedal_to_pwm_slew_limiter.sv =====
// Self-checking testbench for the pedal-to-PWM slew limiter top level.
module tb_pedal_to_pwm_slew_limiter
    import ptp_slew_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Full-scale value of the pedal map, matching the block's default build.
    localparam longint PEDAL_FULL  = FULL_SCALE_DEF;
    // Watchdog bound on the whole run, in clock cycles.
    localparam int     CYCLE_LIMIT = 500000;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int     LONG_HOLD   = 600;
    // Settle time after the last result, longer than the block's latency.
    localparam int     TAIL_CYCLES = 100;

    // One control tick as offered on the s_ channel.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pedal;
        logic                ovr;
        logic [SAMPLE_W-1:0] lvl;
    } tick_t;

    // One result word as carried on the m_ channel.
    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [DUTY_W-1:0]   demand;
        logic [SCALED_W-1:0] scaled;
        logic                fault;
    } pwm_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // pedal_sample[9:0], override_level[19:10]
    logic                 s_tuser   = 1'b0; // override_on
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;          // duty_out[9:0], throttle_demand[19:10],
                                            // pedal_scaled[40:20]
    logic                 m_tuser;          // range_fault
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    // Shadow copy of the register file, starting from the reset values.
    logic [DUTY_W-1:0]    min_duty_r   = RST_MIN_DUTY;
    logic [DUTY_W-1:0]    max_duty_r   = RST_MAX_DUTY;
    logic [SAMPLE_W-1:0]  ped_low_r    = RST_PEDAL_LOW;
    logic [SAMPLE_W-1:0]  ped_high_r   = RST_PEDAL_HIGH;
    logic [DBAND_W-1:0]   low_db_r     = RST_LOW_DBAND;
    logic [DBAND_W-1:0]   high_db_r    = RST_HIGH_DBAND;
    logic [DUTY_W-1:0]    accel_r      = RST_ACCEL_STEP;
    logic [DUTY_W-1:0]    decel_r      = RST_DECEL_STEP;
    // Shadow of the kept duty level.
    logic [DUTY_W-1:0]    duty_level_r = '0;

    tick_t     tick_queue[$];       // ticks waiting to be offered
    pwm_word_t pwm_results_due[$];  // result words owed by the block, oldest first

    bit idle_on      = 1'b0;        // random gaps and stalls enabled
    int errors       = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int settings_cnt = 1;           // reset defaults count as the first setting

    pedal_to_pwm_slew_limiter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Arduino-style linear map; signed division truncating toward zero.
    function automatic longint scale_span(input longint x, input longint in_lo,
                                          input longint in_hi, input longint out_lo,
                                          input longint out_hi);
        longint span;
        span = in_hi - in_lo;
        if (span == 0) return out_lo;
        return (x - in_lo) * (out_hi - out_lo) / span + out_lo;
    endfunction

    // Lower bound is checked first: with crossed bounds, a value below it gets the lower bound, any other the upper.
    function automatic longint clamp_duty(input longint x, input longint lo, input longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Work out the result word of one tick and advance the shadow duty level.
    function automatic pwm_word_t next_pwm_word(input tick_t t);
        pwm_word_t r;
        longint    lo, hi, p_lo, p_hi, ldb, hdb, acc, dec;
        longint    scaled, src, demand, lvl;
        logic      fault;
        lo     = longint'(min_duty_r);
        hi     = longint'(max_duty_r);
        p_lo   = longint'(ped_low_r);
        p_hi   = longint'(ped_high_r);
        ldb    = longint'(low_db_r);
        hdb    = longint'(high_db_r);
        acc    = longint'(accel_r);
        dec    = longint'(decel_r);
        lvl    = longint'(duty_level_r);
        fault  = (p_lo == p_hi);
        scaled = fault ? longint'(0)
                       : scale_span(longint'(t.pedal), p_lo, p_hi, longint'(0), PEDAL_FULL);
        src    = t.ovr ? longint'(t.lvl) : scaled;
        demand = clamp_duty(scale_span(src, ldb, PEDAL_FULL - hdb, lo, hi), lo, hi);
        if (demand > lvl) begin
            lvl = (demand < lvl + acc) ? demand : lvl + acc;
        end else if (demand < lvl) begin
            lvl = (demand > lvl - dec) ? demand : lvl - dec;
        end
        lvl          = clamp_duty(lvl, lo, hi);
        duty_level_r = lvl[DUTY_W-1:0];
        r.duty       = lvl[DUTY_W-1:0];
        r.demand     = demand[DUTY_W-1:0];
        r.scaled     = scaled[SCALED_W-1:0];
        r.fault      = fault;
        return r;
    endfunction

    // Sender: present one tick at a time, with a random idle gap between ticks while idling is on.
    always @(posedge aclk) begin : drive_ticks
        logic  holding;
        int    gap_left;
        tick_t cur_tick;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_left = 0;
            cur_tick = '0;
        end else begin
            holding = s_tvalid;
            if (s_tvalid && s_tready) begin
                // Predict at acceptance so the register shadow matches this word.
                pwm_results_due.push_back(next_pwm_word(cur_tick));
                ticks_sent++;
                holding  = 1'b0;
                gap_left = idle_on ? int'($urandom_range(0, 19)) : 0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_queue.size() != 0) begin
                    cur_tick = tick_queue.pop_front();
                    holding  = 1'b1;
                end
            end
            s_tvalid <= holding;
            s_tdata  <= {4'b0, cur_tick.lvl, cur_tick.pedal};
            s_tuser  <= cur_tick.ovr;
        end
    end

    // Receiver: check every word against the oldest prediction, then stall a while.
    always @(posedge aclk) begin : watch_results
        pwm_word_t want, seen;
        int        stall_left;
        int        long_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            long_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[9:0], m_tdata[19:10], m_tdata[40:20], m_tuser};
                if (pwm_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, duty %0d demand %0d scaled %0d fault %0b",
                             $time, seen.duty, seen.demand, $signed(seen.scaled), seen.fault);
                end else begin
                    want = pwm_results_due.pop_front();
                    if (seen.duty !== want.duty) begin
                        errors++;
                        $display("%0t: duty_out expected %0d, got %0d",
                                 $time, want.duty, seen.duty);
                    end
                    if (seen.demand !== want.demand) begin
                        errors++;
                        $display("%0t: throttle_demand expected %0d, got %0d",
                                 $time, want.demand, seen.demand);
                    end
                    if (seen.scaled !== want.scaled) begin
                        errors++;
                        $display("%0t: pedal_scaled expected %0d, got %0d",
                                 $time, $signed(want.scaled), $signed(seen.scaled));
                    end
                    if (seen.fault !== want.fault) begin
                        errors++;
                        $display("%0t: range_fault expected %0b, got %0b",
                                 $time, want.fault, seen.fault);
                    end
                end
                results_seen++;
                stall_left = idle_on ? int'($urandom_range(0, 19)) : 0;
                // Hold off long enough that the block fills and drops s_tready.
                if (results_seen == 60 || results_seen == 380) long_left = LONG_HOLD;
            end else if (m_tvalid && stall_left > 0) begin
                // Count the short stall only against a waiting word.
                stall_left--;
            end
            if (long_left > 0) long_left--;
            m_tready <= (stall_left == 0 && long_left == 0);
        end
    end

    // Write one register and mirror it in the shadow copy; 9-bit fields drop bit 9.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MIN_DUTY:   min_duty_r = val;
            CFG_MAX_DUTY:   max_duty_r = val;
            CFG_PEDAL_LOW:  ped_low_r  = val;
            CFG_PEDAL_HIGH: ped_high_r = val;
            CFG_LOW_DBAND:  low_db_r   = val[DBAND_W-1:0];
            CFG_HIGH_DBAND: high_db_r  = val[DBAND_W-1:0];
            CFG_ACCEL_STEP: accel_r    = val;
            CFG_DECEL_STEP: decel_r    = val;
            default: ;
        endcase
    endtask

    // Program the whole register file, back to back, then release the write enable.
    task automatic program_regs(input logic [9:0] mn, input logic [9:0] mx,
                                input logic [9:0] pl, input logic [9:0] ph,
                                input logic [9:0] ldb, input logic [9:0] hdb,
                                input logic [9:0] acc, input logic [9:0] dec);
        write_reg(CFG_MIN_DUTY, mn);
        write_reg(CFG_MAX_DUTY, mx);
        write_reg(CFG_PEDAL_LOW, pl);
        write_reg(CFG_PEDAL_HIGH, ph);
        write_reg(CFG_LOW_DBAND, ldb);
        write_reg(CFG_HIGH_DBAND, hdb);
        write_reg(CFG_ACCEL_STEP, acc);
        write_reg(CFG_DECEL_STEP, dec);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_cnt++;
    endtask

    // Zero, the top of the field, any 10-bit value, or a small typical value.
    function automatic logic [9:0] pick_setting(input int top);
        case ($urandom_range(0, 5))
            0:       return 10'd0;
            1:       return top[9:0];
            2:       return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(1, 60));
        endcase
    endfunction

    // Draw a random setting: mostly sane ranges, sometimes empty, inverted or crossed.
    task automatic rand_regs();
        logic [9:0] mn, mx, pl, ph;
        int         pick;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) begin
            pl = 10'($urandom_range(0, 1023));
            ph = pl;
        end else if (pick == 1) begin
            pl = 10'($urandom_range(512, 1023));
            ph = 10'($urandom_range(0, 511));
        end else if (pick == 2) begin
            pl = 10'($urandom_range(0, 1022));
            ph = pl + 10'd1;
        end else begin
            pl = 10'($urandom_range(0, 300));
            ph = 10'($urandom_range(700, 1023));
        end
        pick = int'($urandom_range(0, 7));
        if (pick == 0) begin
            mn = 10'($urandom_range(512, 1023));
            mx = 10'($urandom_range(0, 511));
        end else if (pick == 1) begin
            mn = 10'd0;
            mx = 10'd1023;
        end else begin
            mn = 10'($urandom_range(0, 400));
            mx = 10'($urandom_range(int'(mn), 1023));
        end
        program_regs(mn, mx, pl, ph, pick_setting(511), pick_setting(511),
                     pick_setting(1023), pick_setting(1023));
    endtask

    task automatic push_tick(input logic [9:0] pedal, input logic ovr, input logic [9:0] lvl);
        tick_queue.push_back({pedal, ovr, lvl});
    endtask

    // Queue runs of steady pedal with small jitter so the slew settles; some noise ticks.
    task automatic queue_random_ticks(input int count);
        int         left, run, base, p;
        logic       ovr;
        logic [9:0] lvl;
        left = count;
        while (left > 0) begin
            run = int'($urandom_range(1, 16));
            case ($urandom_range(0, 5))
                0:       base = 0;
                1:       base = 1023;
                default: base = int'($urandom_range(0, 1023));
            endcase
            ovr = ($urandom_range(0, 3) == 0);
            lvl = 10'($urandom);
            for (int k = 0; k < run && left > 0; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_tick(10'($urandom), 1'($urandom), 10'($urandom));
                end else begin
                    p = base + int'($urandom_range(0, 8)) - 4;
                    if (p < 0) p = 0;
                    if (p > 1023) p = 1023;
                    push_tick(p[9:0], ovr, lvl);
                end
                left--;
            end
        end
    endtask

    // Wait until every queued tick has gone and every result has come.
    task automatic wait_drain();
        @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || pwm_results_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : run_test
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults, no idling: pedal extremes, slew ramp, override across
        // the deadband edges.
        @(negedge aclk);
        push_tick(10'd0, 1'b0, 10'd0);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd512, 1'b0, 10'd1023);
        push_tick(10'd0, 1'b1, 10'd1023);
        push_tick(10'd1023, 1'b1, 10'd0);
        push_tick(10'd0, 1'b1, 10'd50);
        push_tick(10'd1023, 1'b1, 10'd973);
        wait_drain();
        idle_on = 1'b1;

        // Empty pedal range: fault raised, pedal taken as zero; override still works.
        program_regs(10'd0, 10'd1023, 10'd300, 10'd300, 10'd0, 10'd0, 10'd1023, 10'd1023);
        @(negedge aclk);
        push_tick(10'd0, 1'b0, 10'd0);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd300, 1'b1, 10'd1023);
        push_tick(10'd777, 1'b0, 10'd512);
        wait_drain();

        // Crossed duty bounds, widest deadbands, zero accel step, one-count pedal span
        // driving pedal_scaled far negative.
        program_regs(10'd800, 10'd200, 10'd1000, 10'd1001, 10'd511, 10'd511, 10'd0, 10'd1023);
        @(negedge aclk);
        push_tick(10'd0, 1'b0, 10'd0);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd1001, 1'b1, 10'd700);
        push_tick(10'd512, 1'b1, 10'd511);
        wait_drain();

        // Inverted pedal range, zero-width duty range, smallest steps.
        program_regs(10'd0, 10'd0, 10'd1023, 10'd1022, 10'd0, 10'd0, 10'd1, 10'd0);
        @(negedge aclk);
        push_tick(10'd0, 1'b0, 10'd1023);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd1022, 1'b1, 10'd1);
        wait_drain();

        // Duty bounds and steps at the top; deadband writes carry bit 9, which must be dropped.
        program_regs(10'd1023, 10'd1023, 10'd0, 10'd1, 10'h3FF, 10'h200, 10'd1023, 10'd1023);
        @(negedge aclk);
        push_tick(10'd1023, 1'b0, 10'd0);
        push_tick(10'd0, 1'b1, 10'd1023);
        wait_drain();

        // Random settings, one phase each; the fifth runs without idling.
        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph != 4);
            rand_regs();
            @(negedge aclk);
            queue_random_ticks(82);
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("ran %0d ticks over %0d register settings, incl. empty, inverted and",
                 ticks_sent, settings_cnt);
        $display("one-count pedal ranges and crossed duty bounds; %0d words checked, %0d errors",
                 results_seen, errors);
        if (errors == 0 && pwm_results_due.size() == 0) begin
            $display("pedal_to_pwm_slew_limiter test passed");
        end else begin
            $display("pedal_to_pwm_slew_limiter test failed");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycles, pwm_results_due.size());
        $display("pedal_to_pwm_slew_limiter test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/ptp_slew_pkg.sv
src/ptp_slew_div.sv
src/pedal_to_pwm_slew_limiter.sv
verif/tb_pedal_to_pwm_slew_limiter.sv
